// File: src/fscu_pkg.sv
package fscu_pkg;

   localparam int DEFAULT_MAX_SLOTS = 1024;
   localparam int WORD_BITS = 8;
   localparam logic [10:0] SLOT_COUNT_RESET = 11'd1024;

   localparam logic ACT_FILL = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;
   localparam logic ST_DONE = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   typedef struct packed {
      logic        action;
      logic [9:0]  first_slot;
      logic [9:0]  last_slot;
      logic [10:0] want_count;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [9:0]  first_filled;
      logic [9:0]  last_filled;
      logic [10:0] cleared_count;
   } rsp_type;

   typedef struct packed {
      logic sweep;
      logic start;
      logic step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic run_last;
      logic out_free;
   } sts_type;

endpackage

// File: src/free_slot_fill_and_clear_unit.sv
// Occupancy map of up to MAX_SLOTS slots, kept in a RAM of 8-slot words. After reset a clearing
// pass over every word empties the map, and no request is taken meanwhile. Each request visits
// its words in order: from the start word up to the word of the last slot in range, a fill
// stopping early once its wanted count is met. The RAM port does one read-modify-write of a word
// per cycle. One request is worked on at a time; a new one is taken while the previous beat
// waits on rsp_stall.
module free_slot_fill_and_clear_unit import fscu_pkg::*; #(
   parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   cmd_type cmd;
   sts_type sts;

   fscu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fscu_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule

// File: src/fscu_ram.sv
module fscu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/fscu_ctrl.sv
module fscu_ctrl import fscu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [3:0] {
      S_SWEEP = 4'b0001,
      S_IDLE  = 4'b0010,
      S_RUN   = 4'b0100,
      S_POST  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (sts.run_last) state_in = S_POST;
         end
         S_POST: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_SWEEP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_SWEEP;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != S_IDLE);

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.sweep, cmd.start, cmd.step, cmd.load}))
      else $error("More than one command at once.");
   a_run_after_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> cmd.step)
      else $error("A started item did not step.");
endmodule

// File: src/fscu_datapath.sv
module fscu_datapath import fscu_pkg::*; #(
   parameter int MAX_SLOTS = DEFAULT_MAX_SLOTS
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);
   localparam int DEPTH = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(WORD_BITS);
   localparam int CLG = $clog2(MAX_SLOTS) + 1;
   localparam int IW = (CLG > 11) ? CLG : 11;
   localparam logic [IW-1:0] MAX_N = IW'(MAX_SLOTS);

   logic [10:0]          slot_count_ff;
   logic                 act_ff;
   logic [IW-1:0]        lo_ff, hi_ff, n_ff;
   logic [AW-1:0]        end_ff, cur_ff;
   logic [10:0]          rem_ff, clr_ff;
   logic                 seen_ff;
   logic [9:0]           ff_ff, lf_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [IW-1:0]        sc, n, lo, hi, nm1, end_slot, lo_sh, end_sh, start_sh;
   logic [AW-1:0]        raddr;
   logic [WORD_BITS-1:0] rdata, word;
   logic [10:0]          rem, clr;
   logic                 seen;
   logic [9:0]           ffv, lfv;

   always_comb begin
      sc = IW'(slot_count_ff);
      if (sc == '0) n = IW'(1);
      else if (sc > MAX_N) n = MAX_N;
      else n = sc;
      lo = IW'(req_data.first_slot);
      hi = IW'(req_data.last_slot);
      nm1 = n - IW'(1);
      if (req_data.action == ACT_FILL) end_slot = nm1;
      else end_slot = (hi > nm1) ? nm1 : hi;
      lo_sh = lo >> OW;
      end_sh = end_slot >> OW;
      start_sh = (lo_sh > end_sh) ? end_sh : lo_sh;
   end

   always_comb begin
      logic [IW-1:0] s;
      logic          inr;
      rem = rem_ff;
      clr = clr_ff;
      seen = seen_ff;
      ffv = ff_ff;
      lfv = lf_ff;
      word = rdata;
      for (int j = 0; j < WORD_BITS; j++) begin
         s = IW'({cur_ff, OW'(j)});
         inr = (s >= lo_ff) && (s < n_ff) && ((act_ff == ACT_FILL) || (s <= hi_ff));
         if (inr) begin
            if (act_ff == ACT_CLEAR) begin
               if (word[j]) clr = clr + 11'd1;
               word[j] = 1'b0;
            end else if (!word[j] && rem != '0) begin
               word[j] = 1'b1;
               if (!seen) ffv = s[9:0];
               lfv = s[9:0];
               seen = 1'b1;
               rem = rem - 11'd1;
            end
         end
      end
   end

   assign sts.sweep_last = (cur_ff == AW'(DEPTH - 1));
   assign sts.run_last = (cur_ff == end_ff) || ((act_ff == ACT_FILL) && (rem == '0));
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign raddr = cmd.start ? start_sh[AW-1:0] : cur_ff + AW'(1);

   fscu_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (cmd.sweep | cmd.step),
      .waddr (cur_ff),
      .wdata (cmd.sweep ? '0 : word),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOT_COUNT_RESET;
         cur_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) slot_count_ff <= csr_wdata;
         if (cmd.sweep || cmd.step) cur_ff <= cur_ff + AW'(1);
         else if (cmd.start) cur_ff <= start_sh[AW-1:0];
         if (cmd.load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         act_ff <= req_data.action;
         lo_ff <= lo;
         hi_ff <= hi;
         n_ff <= n;
         end_ff <= end_sh[AW-1:0];
         rem_ff <= (req_data.want_count == '0) ? 11'd1 : req_data.want_count;
         clr_ff <= '0;
         seen_ff <= 1'b0;
         ff_ff <= '0;
         lf_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= rem;
         clr_ff <= clr;
         seen_ff <= seen;
         ff_ff <= ffv;
         lf_ff <= lfv;
      end
      if (cmd.load) begin
         rsp_ff.status <= (act_ff == ACT_FILL && !seen_ff) ? ST_FAIL : ST_DONE;
         rsp_ff.first_filled <= ff_ff;
         rsp_ff.last_filled <= lf_ff;
         rsp_ff.cleared_count <= clr_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_FAIL) |->
      (rsp_ff.first_filled == '0 && rsp_ff.last_filled == '0 && rsp_ff.cleared_count == '0))
      else $error("A failed fill reports slots.");
   a_fill_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.first_filled <= rsp_ff.last_filled))
      else $error("First filled slot lies after the last.");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("Result overwritten before it was taken.");
endmodule

// File: dv/free_slot_fill_and_clear_unit_test.sv
`timescale 1ns / 1ps

module free_slot_fill_and_clear_unit_test import fscu_pkg::*;;

   localparam int NUM_SLOTS = 1024;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   free_slot_fill_and_clear_unit #(.MAX_SLOTS(NUM_SLOTS)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit          occupied[NUM_SLOTS];
   logic [10:0] slot_limit_reg;
   rsp_type     pending_rsp[$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   typedef struct {
      req_type req;
      bit      has_fixed;
      rsp_type fixed_rsp;
   } stim_row_type;

   function automatic int active_slots();
      int n;
      n = slot_limit_reg;
      if (n == 0) n = 1;
      if (n > NUM_SLOTS) n = NUM_SLOTS;
      return n;
   endfunction

   function automatic rsp_type apply_occupancy(req_type r);
      rsp_type res;
      int n, lo, hi, empty, left, want;
      bit seen;
      res = '0;
      n = active_slots();
      lo = r.first_slot;
      hi = r.last_slot;
      seen = 0;
      if (r.action == ACT_FILL) begin
         empty = 0;
         for (int i = lo; i < n; i++) if (!occupied[i]) empty++;
         if (empty == 0) begin
            res.status = ST_FAIL;
         end else begin
            want = r.want_count;
            if (want == 0) want = 1;
            left = (want < empty) ? want : empty;
            for (int i = lo; i < n && left > 0; i++) begin
               if (!occupied[i]) begin
                  if (!seen) begin
                     res.first_filled = i[9:0];
                     seen = 1;
                  end
                  res.last_filled = i[9:0];
                  occupied[i] = 1;
                  left--;
               end
            end
         end
      end else begin
         if (hi > n - 1) hi = n - 1;
         for (int i = lo; i <= hi; i++) begin
            if (occupied[i]) res.cleared_count++;
            occupied[i] = 0;
         end
      end
      return res;
   endfunction

   function automatic req_type make_req(logic act, int lo, int hi, int want);
      req_type r;
      r.action = act;
      r.first_slot = lo[9:0];
      r.last_slot = hi[9:0];
      r.want_count = want[10:0];
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic st, int ff, int lf, int cnt);
      rsp_type r;
      r.status = st;
      r.first_filled = ff[9:0];
      r.last_filled = lf[9:0];
      r.cleared_count = cnt[10:0];
      return r;
   endfunction

   task automatic send_beat(req_type r);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_checked(req_type r);
      pending_rsp.push_back(apply_occupancy(r));
      send_beat(r);
   endtask

   task automatic send_fixed(req_type r, rsp_type fixed);
      void'(apply_occupancy(r));
      pending_rsp.push_back(fixed);
      send_beat(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (140) @(posedge clock);
   endtask

   task automatic write_slot_limit(int value);
      csr_we <= 1'b1;
      csr_wdata <= value[10:0];
      slot_limit_reg = value[10:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic req_type random_req(int n, bit well_formed);
      int lo, hi;
      req_type r;
      if (!well_formed) begin
         r = req_type'($urandom);
         return r;
      end
      lo = $urandom_range(n - 1);
      hi = lo + $urandom_range(($urandom_range(3) == 0) ? 200 : 12);
      if (hi > 1023) hi = 1023;
      if ($urandom_range(1)) begin
         r = make_req(ACT_CLEAR, lo, hi, $urandom_range(2047));
      end else begin
         r = make_req(ACT_FILL, lo, $urandom_range(1023),
                      ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, 16));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_stall <= (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected response beat %p", rsp_data);
         end else begin
            rsp_type want;
            want = pending_rsp.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   initial begin
      #200ms;
      $display("simulation failed");
      $finish;
   end

   initial begin
      stim_row_type table_rows[$];
      int n;
      for (int i = 0; i < NUM_SLOTS; i++) occupied[i] = 0;
      slot_limit_reg = SLOT_COUNT_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      table_rows.push_back('{make_req(ACT_CLEAR, 0, 1023, 1), 1, make_rsp(ST_DONE, 0, 0, 0)});
      table_rows.push_back('{make_req(ACT_FILL, 0, 1023, 0), 1, make_rsp(ST_DONE, 0, 0, 0)});
      table_rows.push_back('{make_req(ACT_FILL, 1023, 0, 1), 1,
                             make_rsp(ST_DONE, 1023, 1023, 0)});
      table_rows.push_back('{make_req(ACT_FILL, 1023, 0, 5), 1, make_rsp(ST_FAIL, 0, 0, 0)});
      table_rows.push_back('{make_req(ACT_FILL, 0, 0, 2047), 0, '0});
      table_rows.push_back('{make_req(ACT_FILL, 0, 0, 1024), 1, make_rsp(ST_FAIL, 0, 0, 0)});
      table_rows.push_back('{make_req(ACT_CLEAR, 500, 400, 0), 1, make_rsp(ST_DONE, 0, 0, 0)});
      table_rows.push_back('{make_req(ACT_CLEAR, 1023, 1023, 0), 1,
                             make_rsp(ST_DONE, 0, 0, 1)});
      table_rows.push_back('{make_req(ACT_CLEAR, 10, 19, 0), 1, make_rsp(ST_DONE, 0, 0, 10)});
      table_rows.push_back('{make_req(ACT_FILL, 5, 0, 20), 0, '0});
      table_rows.push_back('{make_req(ACT_CLEAR, 0, 1023, 2047), 1,
                             make_rsp(ST_DONE, 0, 0, 1024)});
      table_rows.push_back('{make_req(ACT_FILL, 1, 0, 1024), 1, make_rsp(ST_DONE, 1, 1023, 0)});
      foreach (table_rows[k]) begin
         if (table_rows[k].has_fixed) send_fixed(table_rows[k].req, table_rows[k].fixed_rsp);
         else send_checked(table_rows[k].req);
      end
      drain();

      write_slot_limit(0);
      send_checked(make_req(ACT_CLEAR, 0, 1023, 0));
      send_checked(make_req(ACT_FILL, 0, 0, 3));
      send_fixed(make_req(ACT_FILL, 1, 0, 3), make_rsp(ST_FAIL, 0, 0, 0));
      drain();
      write_slot_limit(2047);
      send_checked(make_req(ACT_CLEAR, 0, 1023, 0));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         case (phase)
            0: write_slot_limit(1024);
            1: write_slot_limit(1);
            2: write_slot_limit(2);
            3: write_slot_limit($urandom_range(3, 1023));
            4: write_slot_limit(1024);
            5: write_slot_limit($urandom_range(2047));
            6: write_slot_limit($urandom_range(16, 128));
            default: write_slot_limit(1024);
         endcase
         n = active_slots();
         for (int k = 0; k < 238; k++) send_checked(random_req(n, $urandom_range(9) != 0));
         send_idle_pct = 0;
         drain();
      end

      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
